FILE: src/iss_pkg.sv
// Shared types, sizes and codes of the irrigation slot scheduler.
package iss_pkg;

  localparam int RELAY_COUNT     = 3;
  localparam int SLOTS_PER_RELAY = 8;
  localparam int CELL_COUNT      = RELAY_COUNT * SLOTS_PER_RELAY;

  localparam int RIDX_W = 2;
  localparam int SIDX_W = 3;
  localparam int MIN_W  = 11;
  localparam int EVT_W  = 13;
  localparam int MS_W   = 32;
  localparam int MODE_W = 2;

  localparam int DAY_MINUTES      = 24 * 60;
  localparam int IDLE_RECHECK     = 60;
  localparam int DEFAULT_INTERVAL = 60000;

  localparam logic [0:0] REQ_SLOT_WRITE = 1'b0;
  localparam logic [0:0] REQ_TICK       = 1'b1;

  localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF      = 2'd2;

  localparam logic [1:0] REG_RUN_MODE       = 2'd0;
  localparam logic [1:0] REG_MANUAL_MASK    = 2'd1;
  localparam logic [1:0] REG_RELAYS_IN_USE  = 2'd2;
  localparam logic [1:0] REG_CHECK_INTERVAL = 2'd3;

  typedef struct packed {
    logic [0:0]        req_type;
    logic [RIDX_W-1:0] relay_index;
    logic [SIDX_W-1:0] slot_index;
    logic [MIN_W-1:0]  slot_start;
    logic [MIN_W-1:0]  slot_duration;
    logic              slot_valid;
    logic [MIN_W-1:0]  minute_of_day;
    logic [MS_W-1:0]   now_ms;
  } iss_req_t;

  typedef struct packed {
    logic [RELAY_COUNT-1:0] relay_drive;
    logic                   pump_drive;
    logic                   evaluated;
    logic                   changed;
    logic [EVT_W-1:0]       next_event;
  } iss_rsp_t;

  typedef struct packed {
    logic [1:0]      addr;
    logic [MS_W-1:0] data;
  } iss_cfg_t;

  // Slot write request broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] relay;
    logic [SIDX_W-1:0] slot;
    logic [MIN_W-1:0]  start;
    logic [MIN_W-1:0]  len;
    logic              valid;
  } iss_wr_t;

  // Evaluation context: the minute is held steady while a scan travels the chain; the relay limit follows its register.
  typedef struct packed {
    logic [MIN_W-1:0]  minute;
    logic [RIDX_W-1:0] relay_limit;
  } iss_bcast_t;

  // Partial result handed from cell to cell.
  typedef struct packed {
    logic                   valid;
    logic [RELAY_COUNT-1:0] wanted;
    logic                   found;
    logic [EVT_W-1:0]       best;
  } iss_link_t;

endpackage

FILE: src/iss_if.sv
// Channel interfaces of the irrigation slot scheduler.
interface iss_req_if import iss_pkg::*; ();
  logic     valid;
  logic     ready;
  iss_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iss_rsp_if import iss_pkg::*; ();
  logic     valid;
  logic     ready;
  iss_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iss_cfg_if import iss_pkg::*; ();
  logic     valid;
  logic     ready;
  iss_cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/irrigation_slot_scheduler.sv
// Slot writes, manual and off ticks, and ticks that are not due go from the
// idle state through the hold state to the registered result; an evaluating
// tick first runs a scan through all 24 slot cells and then the state update.
// No new item is taken until the result of the last one is registered, and
// the result waits while the response is not taken. Synchronous active-high reset
// clears slot valid bits, levels, tracking, timers and loads register defaults.
module irrigation_slot_scheduler import iss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  iss_req_if.sink   req,
  iss_rsp_if.source rsp,
  iss_cfg_if.sink   cfg
);

  // The sequencer accepts one item at a time. Slot writes land directly in
  // the addressed cell; every cell compares the write's relay and slot
  // numbers against its own position, so out-of-range writes match nothing.
  iss_wr_t    wr;
  iss_bcast_t bcast;

  // The scan record enters at the head of the chain and moves one cell per
  // cycle. Each cell ORs its relay's wanted bit into the record when the
  // present minute lies in its slot, and offers its earliest later event as a
  // candidate for the next event minute. The record leaving the last cell
  // carries the whole evaluation back to the sequencer.
  iss_link_t  link [CELL_COUNT+1];

  iss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg),
    .wr    (wr),
    .bcast (bcast),
    .head  (link[0]),
    .tail  (link[CELL_COUNT])
  );

  // Cell k holds slot k % SLOTS_PER_RELAY of relay k / SLOTS_PER_RELAY.
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    iss_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .relay_id (RIDX_W'(k / SLOTS_PER_RELAY)),
      .slot_id  (SIDX_W'(k % SLOTS_PER_RELAY)),
      .wr       (wr),
      .bcast    (bcast),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

endmodule

FILE: src/iss_cell.sv
// One schedule slot cell: holds a slot and folds it into the passing scan.
module iss_cell import iss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [RIDX_W-1:0] relay_id,
  input  logic [SIDX_W-1:0] slot_id,
  input  iss_wr_t           wr,
  input  iss_bcast_t        bcast,
  input  iss_link_t         link_in,
  output iss_link_t         link_out
);

  logic [MIN_W-1:0] start;
  logic [MIN_W-1:0] len;
  logic             valid;

  logic [MIN_W:0]   start_x;
  logic [MIN_W:0]   minute_x;
  logic [MIN_W:0]   end_min;
  logic [MIN_W:0]   start_day;
  logic [MIN_W:0]   cand;
  logic             in_slot;
  logic             used;
  iss_link_t        link_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.relay == relay_id && wr.slot == slot_id) begin
      valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.relay == relay_id && wr.slot == slot_id) begin
      start <= wr.start;
      len   <= wr.len;
    end
  end

  always_comb begin
    start_x   = {1'b0, start};
    minute_x  = {1'b0, bcast.minute};
    end_min   = start_x + {1'b0, len};
    start_day = start_x + (MIN_W+1)'(DAY_MINUTES);
    in_slot   = valid && (len != '0) && (minute_x >= start_x) && (minute_x < end_min);
    used      = valid && (relay_id < bcast.relay_limit);
    // The end plus one day never beats the start plus one day.
    if (start_x > minute_x) begin
      cand = start_x;
    end else if (end_min > minute_x && end_min < start_day) begin
      cand = end_min;
    end else begin
      cand = start_day;
    end
    link_next = link_in;
    if (in_slot) begin
      link_next.wanted = link_in.wanted | (RELAY_COUNT'(1) << relay_id);
    end
    if (used && (!link_in.found || EVT_W'(cand) < link_in.best)) begin
      link_next.found = 1'b1;
      link_next.best  = EVT_W'(cand);
    end
  end

  // Only the valid bit of the scan record is reset; the rest follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_next.valid;
    end
    link_out.wanted <= link_next.wanted;
    link_out.found  <= link_next.found;
    link_out.best   <= link_next.best;
  end

endmodule

FILE: src/iss_ctrl.sv
// Sequencer: configuration, mode handling, scan launch and result register.
module iss_ctrl import iss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  iss_req_if.sink    req,
  iss_rsp_if.source  rsp,
  iss_cfg_if.sink    cfg,
  output iss_wr_t    wr,
  output iss_bcast_t bcast,
  output iss_link_t  head,
  input  iss_link_t  tail
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]             state;
  logic [MODE_W-1:0]      run_mode;
  logic [RELAY_COUNT-1:0] manual_mask;
  logic [RIDX_W-1:0]      relays_in_use;
  logic [MS_W-1:0]        check_interval;
  logic [MS_W-1:0]        last_check;
  logic [EVT_W-1:0]       next_evt;
  logic [RELAY_COUNT-1:0] tracked_relays;
  logic                   tracked_pump;
  logic [RELAY_COUNT-1:0] relay_levels;
  logic                   pump_level;
  logic                   eval_flag;
  logic                   chg_flag;
  logic [MIN_W-1:0]       tick_minute;
  logic                   launch;
  logic                   out_valid;
  iss_rsp_t               out_data;

  logic [RIDX_W-1:0]      nrel;
  logic [RELAY_COUNT-1:0] in_use;
  logic                   accept;
  logic                   due;
  logic [RELAY_COUNT-1:0] scan_on;
  logic [RELAY_COUNT-1:0] scan_flip;
  logic                   scan_pump;
  logic                   out_free;

  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;
  assign out_free    = !out_valid || rsp.ready;

  always_comb begin
    nrel = (32'(relays_in_use) > RELAY_COUNT) ? RIDX_W'(RELAY_COUNT) : relays_in_use;
    for (int r = 0; r < RELAY_COUNT; r++) begin
      in_use[r] = RIDX_W'(r) < nrel;
    end
    due = ((next_evt != '0) && ({2'b00, req.payload.minute_of_day} >= next_evt)) ||
          ((req.payload.now_ms - last_check) >= check_interval);
    scan_on   = tail.wanted & in_use;
    scan_flip = (scan_on ^ tracked_relays) & in_use;
    scan_pump = |scan_on;
  end

  always_comb begin
    wr.en    = accept && (req.payload.req_type == REQ_SLOT_WRITE);
    wr.relay = req.payload.relay_index;
    wr.slot  = req.payload.slot_index;
    wr.start = req.payload.slot_start;
    wr.len   = req.payload.slot_duration;
    wr.valid = req.payload.slot_valid;
    bcast.minute      = tick_minute;
    bcast.relay_limit = nrel;
    head.valid  = launch;
    head.wanted = '0;
    head.found  = 1'b0;
    head.best   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= MODE_SCHEDULE;
      manual_mask    <= '0;
      relays_in_use  <= RIDX_W'(RELAY_COUNT);
      check_interval <= MS_W'(DEFAULT_INTERVAL);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.payload.addr)
        REG_RUN_MODE:       run_mode       <= cfg.payload.data[MODE_W-1:0];
        REG_MANUAL_MASK:    manual_mask    <= cfg.payload.data[RELAY_COUNT-1:0];
        REG_RELAYS_IN_USE:  relays_in_use  <= cfg.payload.data[RIDX_W-1:0];
        REG_CHECK_INTERVAL: check_interval <= cfg.payload.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      launch         <= 1'b0;
      last_check     <= '0;
      next_evt       <= '0;
      tracked_relays <= '0;
      tracked_pump   <= 1'b0;
      relay_levels   <= '0;
      pump_level     <= 1'b0;
      eval_flag      <= 1'b0;
      chg_flag       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            eval_flag <= 1'b0;
            chg_flag  <= 1'b0;
            state     <= ST_HOLD;
            if (req.payload.req_type == REQ_TICK) begin
              unique case (run_mode)
                MODE_SCHEDULE: begin
                  if (due) begin
                    last_check <= req.payload.now_ms;
                    launch     <= 1'b1;
                    state      <= ST_SCAN;
                  end
                end
                MODE_MANUAL: begin
                  relay_levels <= (relay_levels & ~in_use) | (manual_mask & in_use);
                  pump_level   <= |(manual_mask & in_use);
                end
                default: begin
                  relay_levels <= '0;
                  pump_level   <= 1'b0;
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            relay_levels   <= (relay_levels & ~in_use) | scan_on;
            pump_level     <= scan_pump;
            tracked_relays <= tracked_relays ^ scan_flip;
            tracked_pump   <= scan_pump;
            eval_flag      <= 1'b1;
            chg_flag       <= (scan_flip != '0) || (scan_pump != tracked_pump);
            next_evt       <= tail.found ? tail.best
                              : EVT_W'({2'b00, tick_minute} + EVT_W'(IDLE_RECHECK));
            state          <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_minute <= req.payload.minute_of_day;
    end
    if (state == ST_HOLD && out_free) begin
      out_data.relay_drive <= relay_levels;
      out_data.pump_drive  <= pump_level;
      out_data.evaluated   <= eval_flag;
      out_data.changed     <= chg_flag;
      out_data.next_event  <= next_evt;
    end
  end

`ifndef ASSERT_OFF
  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == ST_SCAN)
    else $error("scan result arrived outside a scan");
  a_launch_enters_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == ST_SCAN)
    else $error("scan launched without the sequencer waiting for it");
  a_change_needs_eval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.changed) |-> out_data.evaluated)
    else $error("change flagged without an evaluation");
  a_eval_sets_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evaluated) |-> out_data.next_event != '0)
    else $error("evaluation left the next event at zero");
  a_scan_finishes: assert property (@(posedge clk) disable iff (rst)
    launch |-> ##(CELL_COUNT) tail.valid)
    else $error("scan did not reach the end of the chain in time");
`endif

endmodule
